// ===== design/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

    localparam int RLD_SIZE_BITS  = 24;   // default width of the declared size
    localparam int RLD_TOTAL_W    = 24;   // width of the total_size field
    localparam int RLD_FIFO_DEPTH = 4;    // result queue entries
    localparam int RLD_FIFO_AW    = 2;    // result queue pointer width
    localparam int RLD_FIFO_CW    = 3;    // result queue fill count width
    localparam int RLD_IN_DW      = 8;    // input tdata width
    localparam int RLD_OUT_DW     = 48;   // output tdata width (42 bits used)

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_HDR_SHORT  = 2'd1;
    localparam logic [1:0] ERR_SRC_SHORT  = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE  = 2'd3;

    localparam logic [7:0] RUN_MIN        = 8'd3;
    localparam logic [7:0] LIT_MIN        = 8'd1;
    localparam logic [7:0] REP_MAX        = 8'd130;

    typedef logic [RLD_TOTAL_W-1:0] t_total;

    typedef struct packed {
        logic       last;
        t_total     total_size;
        logic [1:0] error_code;
        logic [7:0] repeat_count;
        logic [7:0] out_byte;
    } t_item;

    // results of one processed input word, item0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_item      item1;
        t_item      item0;
    } t_push;

endpackage

`default_nettype wire

// ===== design/run_length_decoder_unit.sv =====
// Path: an accepted input word is held in the input register, then decoded
//   into the result queue. Throughput: one input word per cycle while the
//   queue has room for two results; a word that ends a stream with data
//   pending gives two results, which leave the queue one at a time.
// Reset: synchronous, active low; clears decoder state and empties the queue.
// ----------------------------------------------------------------------------
// run_length_decoder_unit
// Run-length decompressor: 4-byte header with 24-bit size, run and literal
// tokens, error reporting on short or oversized streams.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_decoder_unit #(
    parameter int SIZE_BITS = rld_pkg::RLD_SIZE_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [rld_pkg::RLD_IN_DW-1:0]  s_axis_tdata,  // [7:0] src_byte
    input  wire logic                           s_axis_tlast,  // src_last
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] out_byte, [15:8] repeat_count, [17:16] error_code,
    // [41:18] total_size, [47:42] zero
    output logic [rld_pkg::RLD_OUT_DW-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast   // last
);
    import rld_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic                   w_take;
    t_push                  w_push;
    t_item                  w_out;
    logic [RLD_FIFO_CW-1:0] w_fifo_count;

    // decode only with room for two results
    assign w_take        = r_in_valid &&
                           (w_fifo_count <= RLD_FIFO_CW'(RLD_FIFO_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_last <= s_axis_tlast;
        end
    end

    rld_decode #(
        .SIZE_BITS (SIZE_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (w_push)
    );

    rld_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_item  (w_out),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_count (w_fifo_count)
    );

    assign m_axis_tdata = {6'd0, w_out.total_size, w_out.error_code,
                           w_out.repeat_count, w_out.out_byte};
    assign m_axis_tlast = w_out.last;

    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.error_code != ERR_OK) |->
            (m_axis_tlast && w_out.repeat_count == 8'd0 && w_out.out_byte == 8'd0))
        else $error("error word carries data");

    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.error_code == ERR_OK) |->
            (w_out.repeat_count == LIT_MIN ||
             (w_out.repeat_count >= RUN_MIN && w_out.repeat_count <= REP_MAX)))
        else $error("repeat count out of range");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_count <= RLD_FIFO_CW'(RLD_FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |=> m_axis_tvalid)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

// ===== design/rld_decode.sv =====
// ----------------------------------------------------------------------------
// rld_decode
// Stream state and per-word decode: header, tokens, run data and literals.
// Produces up to two result items for the word held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_decode #(
    parameter int SIZE_BITS = rld_pkg::RLD_SIZE_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output rld_pkg::t_push     o_push
);
    import rld_pkg::*;

    localparam int PW = SIZE_BITS + 1;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TOKEN   = 3'd1;
    localparam logic [2:0] PH_RUNDATA = 3'd2;
    localparam logic [2:0] PH_LITERAL = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic [2:0]           r_phase,    n_phase;
    logic [1:0]           r_hdr_cnt,  n_hdr_cnt;
    logic [SIZE_BITS-1:0] r_size,     n_size;
    logic [SIZE_BITS-1:0] r_prod,     n_prod;
    logic [7:0]           r_lit_left, n_lit_left;
    logic [7:0]           r_run_len,  n_run_len;

    logic [RLD_TOTAL_W-1:0] w_hdr_bits;
    logic [SIZE_BITS-1:0]   w_size_upd;
    logic [7:0]             w_len;
    logic                   w_too_large;
    logic                   d_valid;
    t_item                  d_item;
    logic                   f_valid;
    t_item                  f_item;

    // header bytes 1..3 land at bit 0, 8, 16
    assign w_hdr_bits = RLD_TOTAL_W'({16'd0, i_byte} << {r_hdr_cnt - 2'd1, 3'b000});
    assign w_size_upd = (r_phase == PH_HEADER && r_hdr_cnt != 2'd0)
                      ? (r_size | SIZE_BITS'(w_hdr_bits)) : r_size;

    assign w_len       = {1'b0, i_byte[6:0]} + (i_byte[7] ? RUN_MIN : LIT_MIN);
    assign w_too_large = (PW'(r_prod) + PW'(w_len)) > PW'(r_size);

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_size     = w_size_upd;
        n_prod     = r_prod;
        n_lit_left = r_lit_left;
        n_run_len  = r_run_len;
        d_valid    = 1'b0;
        d_item     = '0;
        f_valid    = 1'b0;
        f_item     = '0;

        d_item.total_size = t_total'(w_size_upd);
        f_item.total_size = t_total'(w_size_upd);
        f_item.last       = 1'b1;

        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt == 2'd3) begin
                    n_hdr_cnt = 2'd0;
                    n_phase   = PH_TOKEN;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                end
            end
            PH_TOKEN: begin
                if (w_too_large) begin
                    d_valid           = 1'b1;
                    d_item.error_code = ERR_TOO_LARGE;
                    d_item.last       = 1'b1;
                    n_phase           = PH_DONE;
                end else if (i_byte[7]) begin
                    n_run_len = w_len;
                    n_phase   = PH_RUNDATA;
                end else begin
                    n_lit_left = w_len;
                    n_phase    = PH_LITERAL;
                end
            end
            PH_RUNDATA: begin
                n_prod              = r_prod + SIZE_BITS'(r_run_len);
                d_valid             = 1'b1;
                d_item.out_byte     = i_byte;
                d_item.repeat_count = r_run_len;
                d_item.last         = (n_prod == r_size);
                n_phase             = d_item.last ? PH_DONE : PH_TOKEN;
            end
            PH_LITERAL: begin
                n_lit_left          = r_lit_left - 8'd1;
                n_prod              = r_prod + SIZE_BITS'(1);
                d_valid             = 1'b1;
                d_item.out_byte     = i_byte;
                d_item.repeat_count = LIT_MIN;
                d_item.last         = (n_prod == r_size);
                if (d_item.last) begin
                    n_phase = PH_DONE;
                end else if (n_lit_left == 8'd0) begin
                    n_phase = PH_TOKEN;
                end
            end
            default: begin
            end
        endcase

        // end of source: report a short stream, then start over
        if (i_last) begin
            if (n_phase == PH_HEADER) begin
                f_valid           = 1'b1;
                f_item.error_code = ERR_HDR_SHORT;
            end else if (n_phase != PH_DONE) begin
                f_valid           = 1'b1;
                f_item.error_code = ERR_SRC_SHORT;
            end
            n_phase    = PH_HEADER;
            n_hdr_cnt  = 2'd0;
            n_size     = '0;
            n_prod     = '0;
            n_lit_left = 8'd0;
            n_run_len  = 8'd0;
        end

        o_push       = '0;
        o_push.item0 = d_valid ? d_item : f_item;
        o_push.item1 = f_item;
        if (i_take) begin
            o_push.cnt = {1'b0, d_valid} + {1'b0, f_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= 2'd0;
            r_size     <= '0;
            r_prod     <= '0;
            r_lit_left <= 8'd0;
            r_run_len  <= 8'd0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_size     <= n_size;
            r_prod     <= n_prod;
            r_lit_left <= n_lit_left;
            r_run_len  <= n_run_len;
        end
    end

endmodule

`default_nettype wire

// ===== design/rld_out_fifo.sv =====
// ----------------------------------------------------------------------------
// rld_out_fifo
// Small result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rld_pkg::t_push                i_push,
    output rld_pkg::t_item                     o_item,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [rld_pkg::RLD_FIFO_CW-1:0]    o_count
);
    import rld_pkg::*;

    t_item                  r_mem [RLD_FIFO_DEPTH];
    logic [RLD_FIFO_AW-1:0] r_wptr, n_wptr;
    logic [RLD_FIFO_AW-1:0] r_rptr, n_rptr;
    logic [RLD_FIFO_CW-1:0] r_count, n_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr + RLD_FIFO_AW'(i_push.cnt);
        n_rptr  = r_rptr + RLD_FIFO_AW'(w_pop);
        n_count = r_count + RLD_FIFO_CW'(i_push.cnt) - RLD_FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wptr + RLD_FIFO_AW'(1)] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the run-length decoder: compressed streams (directed
// corner cases, then random well-formed, truncated, oversized and noise
// streams) go in with random gaps on both sides, and every decoded word is
// checked against a cycle-free decoder kept in the scoreboard.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_TOKEN,
    DEC_RUNDATA,
    DEC_LITERAL,
    DEC_DONE
} t_dec_phase;

class decode_checker;
    localparam logic [23:0] SIZE_MASK = 24'((32'd1 << rld_pkg::RLD_SIZE_BITS) - 32'd1);

    rld_pkg::t_item expected_items[$];
    int             fails;

    t_dec_phase     ph;
    logic [1:0]     hdr_cnt;
    logic [23:0]    decl_size;
    logic [23:0]    produced;
    logic [7:0]     lit_left;
    logic [7:0]     run_len;

    function new();
        fails = 0;
        restart();
    endfunction

    function void restart();
        ph        = DEC_HEADER;
        hdr_cnt   = 2'd0;
        decl_size = 24'd0;
        produced  = 24'd0;
        lit_left  = 8'd0;
        run_len   = 8'd0;
    endfunction

    function void flag(string msg);
        fails++;
        if (fails <= 10)
            $display("%s", msg);
    endfunction

    function void push_item(logic [7:0] b, logic [7:0] rep, logic [1:0] err, logic fin);
        rld_pkg::t_item it;
        it.out_byte     = b;
        it.repeat_count = rep;
        it.error_code   = err;
        it.total_size   = decl_size;
        it.last         = fin;
        expected_items.push_back(it);
    endfunction

    function void emit_data(logic [7:0] b, logic [7:0] len);
        logic done;
        produced = produced + 24'(len);
        done     = (produced == decl_size);
        if (done)
            ph = DEC_DONE;
        push_item(b, len, rld_pkg::ERR_OK, done);
    endfunction

    // one accepted input word
    function void decode_byte(logic [7:0] b, logic fin);
        int unsigned len;
        len = 0;
        case (ph)
            DEC_HEADER: begin
                if (hdr_cnt >= 2'd1)
                    decl_size = (decl_size | (24'(b) << (8 * (hdr_cnt - 2'd1)))) & SIZE_MASK;
                if (hdr_cnt >= 2'd3) begin
                    hdr_cnt = 2'd0;
                    ph      = DEC_TOKEN;
                end else begin
                    hdr_cnt++;
                end
            end
            DEC_TOKEN: begin
                len = b[6:0] + (b[7] ? 3 : 1);
                // size check comes before any data of the token is read
                if (32'(produced) + len > 32'(decl_size)) begin
                    push_item(8'd0, 8'd0, rld_pkg::ERR_TOO_LARGE, 1'b1);
                    ph = DEC_DONE;
                end else if (b[7]) begin
                    run_len = 8'(len);
                    ph      = DEC_RUNDATA;
                end else begin
                    lit_left = 8'(len);
                    ph       = DEC_LITERAL;
                end
            end
            DEC_RUNDATA: begin
                ph = DEC_TOKEN;
                emit_data(b, run_len);
            end
            DEC_LITERAL: begin
                lit_left--;
                if (lit_left == 8'd0)
                    ph = DEC_TOKEN;
                emit_data(b, 8'd1);
            end
            default: ;
        endcase
        if (fin) begin
            if (ph == DEC_HEADER)
                push_item(8'd0, 8'd0, rld_pkg::ERR_HDR_SHORT, 1'b1);
            else if (ph != DEC_DONE)
                push_item(8'd0, 8'd0, rld_pkg::ERR_SRC_SHORT, 1'b1);
            restart();
        end
    endfunction

    function void check_item(logic [rld_pkg::RLD_OUT_DW-1:0] data, logic tl);
        rld_pkg::t_item got;
        rld_pkg::t_item exp_it;
        got.out_byte     = data[7:0];
        got.repeat_count = data[15:8];
        got.error_code   = data[17:16];
        got.total_size   = data[41:18];
        got.last         = tl;
        if (expected_items.size() == 0) begin
            flag($sformatf("ERROR: unexpected word byte=%02h rep=%0d err=%0d size=%06h last=%0b",
                 got.out_byte, got.repeat_count, got.error_code, got.total_size, got.last));
            return;
        end
        exp_it = expected_items.pop_front();
        if (got !== exp_it)
            flag($sformatf({"ERROR: exp byte=%02h rep=%0d err=%0d size=%06h last=%0b, ",
                            "got byte=%02h rep=%0d err=%0d size=%06h last=%0b"},
                 exp_it.out_byte, exp_it.repeat_count, exp_it.error_code,
                 exp_it.total_size, exp_it.last,
                 got.out_byte, got.repeat_count, got.error_code, got.total_size, got.last));
    endfunction

    function int pending();
        return expected_items.size();
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 16;
    // words a large stream may need, so the run does not overshoot by much
    localparam int BIG_ROOM     = 450;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [rld_pkg::RLD_IN_DW-1:0]   s_axis_tdata;   // [7:0] src_byte
    logic                            s_axis_tlast;   // src_last
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [7:0] out_byte, [15:8] repeat_count, [17:16] error_code, [41:18] total_size
    logic [rld_pkg::RLD_OUT_DW-1:0]  m_axis_tdata;
    logic                            m_axis_tlast;   // last

    decode_checker dec;
    logic [7:0]    strm[$];
    int            words_sent;
    bit            tx_quiet;
    bit            rx_quiet;
    int            rx_hold;
    int            cycles;

    run_length_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random back-pressure, checks every accepted word
    initial begin
        rx_hold  = 0;
        rx_quiet = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                dec.check_item(m_axis_tdata, m_axis_tlast);
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                rx_hold = rx_quiet ? 0 : $urandom_range(0, 12);
            end
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [7:0] b, logic fin);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        dec.decode_byte(b, fin);
        words_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < strm.size(); i++)
            send_word(strm[i], i == strm.size() - 1);
        strm.delete();
    endtask

    // drop valid and hold off until every expected word is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (dec.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void add_header(logic [23:0] sz);
        strm.push_back(8'($urandom));
        strm.push_back(sz[7:0]);
        strm.push_back(sz[15:8]);
        strm.push_back(sz[23:16]);
    endfunction

    // tokens that fill exactly total bytes
    function automatic void add_body(int unsigned total);
        int unsigned left;
        int unsigned len;
        left = total;
        while (left > 0) begin
            if (left >= 3 && $urandom_range(0, 1)) begin
                len = $urandom_range(3, left < 130 ? left : 130);
                strm.push_back(8'h80 | 8'(len - 3));
                strm.push_back(8'($urandom));
            end else begin
                len = $urandom_range(1, left < 128 ? left : 128);
                strm.push_back(8'(len - 1));
                repeat (len) strm.push_back(8'($urandom));
            end
            left -= len;
        end
    endfunction

    function automatic void add_noise(int n);
        repeat (n) strm.push_back(8'($urandom));
    endfunction

    initial begin
        int unsigned sz;
        int unsigned len;
        int          kind;
        int          cut;
        bit          paused;

        dec        = new();
        words_sent = 0;
        tx_quiet   = 1'b0;
        paused     = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero size, stream stops right after the header
        strm = '{8'h10, 8'h00, 8'h00, 8'h00};
        send_stream();
        // header cut short
        strm = '{8'hFF, 8'h05};
        send_stream();
        // zero size: first token cannot fit
        strm = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
        send_stream();
        // max size, longest run, then the stream ends on a literal: data and error together
        strm = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAB, 8'h00, 8'h55};
        send_stream();
        // shortest run fills the size, trailing byte is ignored
        strm = '{8'hA5, 8'h03, 8'h00, 8'h00, 8'h80, 8'h00, 8'hEE};
        send_stream();

        while (words_sent < RANDOM_ITEMS) begin
            if (!paused && words_sent >= RANDOM_ITEMS / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            sz   = ($urandom_range(0, 9) == 0 && words_sent < RANDOM_ITEMS - BIG_ROOM)
                 ? $urandom_range(100, 400) : $urandom_range(1, 40);
            kind = $urandom_range(0, 19);
            if (kind <= 13) begin
                add_header(24'(sz));
                add_body(sz);
                if ($urandom_range(0, 3) == 0)
                    add_noise($urandom_range(1, 3));
            end else if (kind <= 15) begin
                // truncated well-formed stream, cut may land in the header
                add_header(24'(sz));
                add_body(sz);
                cut = $urandom_range(1, strm.size() - 1);
                while (strm.size() > cut) void'(strm.pop_back());
            end else if (kind == 16) begin
                // first token larger than the declared size
                sz = $urandom_range(0, 20);
                add_header(24'(sz));
                if ($urandom_range(0, 1)) begin
                    len = $urandom_range(sz + 1 > 3 ? sz + 1 : 3, 130);
                    strm.push_back(8'h80 | 8'(len - 3));
                end else begin
                    len = $urandom_range(sz + 1, 128);
                    strm.push_back(8'(len - 1));
                end
                add_noise($urandom_range(0, 2));
            end else if (kind == 17) begin
                // full-range size, random content
                add_noise(4 + $urandom_range(1, 15));
            end else begin
                add_noise($urandom_range(1, 8));
            end
            send_stream();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (dec.pending() != 0) begin
            void'(dec.expected_items.pop_front());
            dec.flag("ERROR: expected word never arrived");
        end

        if (dec.fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
